/* rtl/core/cvl_pkg.sv */
// Shared types, codes and sizes of the compacting value list.
package cvl_pkg;

  localparam int DEPTH = 16;
  localparam int POS_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int FUNC_W = 3;
  localparam int STATUS_W = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_GET = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOMATCH = 2'd3;

  typedef enum logic [2:0] {
    K_APPEND,
    K_GET,
    K_SET,
    K_REMOVE,
    K_SEARCH,
    K_NONE
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    logic [POS_W-1:0] pos;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_state_t;

endpackage

/* rtl/core/compacting_value_list_top.sv */
// Top level of the compacting value list: front queue, back end and checks.
// An accepted transaction passes through the queue entry, the compare step, which
// registers the match vector, and the execute step, which loads the output register.
// The two-step back-end sequencer takes a new transaction only once the last is done.
// The two-entry input queue accepts until full while a result waits on a stalled output.
// Reset (rst_n, synchronous, active low) empties the queue and the list and clears
// the output valid; the entry store itself is not cleared and is read only once written.
module compacting_value_list_top
  import cvl_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [FUNC_W-1:0]         in_func,
  input  logic [POS_W-1:0]          in_position,
  input  logic signed [VAL_W-1:0]   in_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VAL_W-1:0]   out_read_value,
  output logic                      out_found,
  output logic [POS_W-1:0]          out_found_index,
  output logic [CNT_W-1:0]          out_entry_count,
  output logic [STATUS_W-1:0]       out_status
);

  // Decoded transactions travel from the front queue to the back end as one struct.
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  // The front end decodes the function code into an operation kind, so that the
  // back end never sees the unused codes, and buffers up to two transactions.
  cvl_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_func     (in_func),
    .in_position (in_position),
    .in_value    (in_value),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop)
  );

  // The back end owns the entry registers and the count. It registers the match
  // vector of every entry against the value in its first step, then applies the
  // operation and loads the output register in its second step. The list only
  // changes in the step that also produces the result, so a stalled output simply
  // holds the back end in that step.
  cvl_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_value  (out_read_value),
    .out_found       (out_found),
    .out_found_index (out_found_index),
    .out_entry_count (out_entry_count),
    .out_status      (out_status)
  );

  // The reported count can never exceed the capacity of the list.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count <= CNT_W'(DEPTH)))
    else $error("entry count above list depth");

  // A hit must lie among the valid entries and carries an ok status.
  a_found_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |->
      (({1'b0, out_found_index} < out_entry_count) && (out_status == STATUS_OK)))
    else $error("search hit outside the valid entries");

  // A failed search reports neither a hit nor an index.
  a_nomatch_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STATUS_NOMATCH)) |->
      (!out_found && (out_found_index == '0)))
    else $error("failed search reports a hit");

  // The back end only takes from the queue when the queue holds something.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from an empty queue");

endmodule

/* rtl/core/cvl_front.sv */
// Front end: decodes incoming transactions and holds them in a short queue.
module cvl_front
  import cvl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [FUNC_W-1:0]       in_func,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    q_valid,
  output cmd_t                    q_cmd,
  input  logic                    q_pop
);

  cmd_t                queue_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   fill_r, fill_nxt;
  logic                push;
  cmd_t                dec_cmd;

  always_comb begin
    dec_cmd.pos = in_position;
    dec_cmd.value = in_value;
    case (in_func)
      FUNC_APPEND: dec_cmd.kind = K_APPEND;
      FUNC_GET:    dec_cmd.kind = K_GET;
      FUNC_SET:    dec_cmd.kind = K_SET;
      FUNC_REMOVE: dec_cmd.kind = K_REMOVE;
      FUNC_SEARCH: dec_cmd.kind = K_SEARCH;
      default:     dec_cmd.kind = K_NONE;
    endcase
  end

  assign in_stall = (fill_r == QCNT_W'(QUEUE_DEPTH));
  assign push = in_valid && !in_stall;
  assign q_valid = (fill_r != '0);
  assign q_cmd = queue_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt = fill_r + QCNT_W'(push) - QCNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= dec_cmd;
    end
  end

endmodule

/* rtl/core/cvl_back.sv */
// Back end: compares, updates the entry store and registers each result.
module cvl_back
  import cvl_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  cmd_t                      q_cmd,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VAL_W-1:0]   out_read_value,
  output logic                      out_found,
  output logic [POS_W-1:0]          out_found_index,
  output logic [CNT_W-1:0]          out_entry_count,
  output logic [STATUS_W-1:0]       out_status
);

  back_state_t             state_r, state_nxt;
  cmd_t                    cmd_r, cmd_nxt;
  logic [DEPTH-1:0]        match_r, match_nxt;
  logic signed [VAL_W-1:0] entries_r [DEPTH];
  logic signed [VAL_W-1:0] entries_nxt [DEPTH];
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] rd_r, rd_nxt;
  logic                    fnd_r, fnd_nxt;
  logic [POS_W-1:0]        fidx_r, fidx_nxt;
  logic [CNT_W-1:0]        cnt_out_r, cnt_out_nxt;
  logic [STATUS_W-1:0]     st_r, st_nxt;
  logic                    in_range;

  assign in_range = {1'b0, cmd_r.pos} < count_r;

  always_comb begin
    state_nxt = state_r;
    q_pop = 1'b0;
    cmd_nxt = cmd_r;
    match_nxt = match_r;
    entries_nxt = entries_r;
    count_nxt = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_nxt = rd_r;
    fnd_nxt = fnd_r;
    fidx_nxt = fidx_r;
    cnt_out_nxt = cnt_out_r;
    st_nxt = st_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          cmd_nxt = q_cmd;
          for (int i = 0; i < DEPTH; i++) begin
            match_nxt[i] = (entries_r[i] == q_cmd.value) && (CNT_W'(i) < count_r);
          end
          state_nxt = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          rd_nxt = '0;
          fnd_nxt = 1'b0;
          fidx_nxt = '0;
          st_nxt = STATUS_OK;
          case (cmd_r.kind)
            K_APPEND: begin
              if (count_r >= CNT_W'(DEPTH)) begin
                st_nxt = STATUS_FULL;
              end else begin
                entries_nxt[count_r[POS_W-1:0]] = cmd_r.value;
                count_nxt = count_r + 1'b1;
              end
            end
            K_GET: begin
              if (in_range) begin
                rd_nxt = entries_r[cmd_r.pos];
              end else begin
                st_nxt = STATUS_RANGE;
              end
            end
            K_SET: begin
              if (in_range) begin
                entries_nxt[cmd_r.pos] = cmd_r.value;
              end else begin
                st_nxt = STATUS_RANGE;
              end
            end
            K_REMOVE: begin
              if (in_range) begin
                for (int i = 0; i < DEPTH - 1; i++) begin
                  if (POS_W'(i) >= cmd_r.pos) begin
                    entries_nxt[i] = entries_r[i+1];
                  end
                end
                count_nxt = count_r - 1'b1;
              end else begin
                st_nxt = STATUS_RANGE;
              end
            end
            K_SEARCH: begin
              st_nxt = STATUS_NOMATCH;
              for (int i = DEPTH - 1; i >= 0; i--) begin
                if (match_r[i]) begin
                  fnd_nxt = 1'b1;
                  fidx_nxt = POS_W'(i);
                  st_nxt = STATUS_OK;
                end
              end
            end
            default: begin
            end
          endcase
          cnt_out_nxt = count_nxt;
          out_valid_nxt = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    match_r <= match_nxt;
    entries_r <= entries_nxt;
    rd_r <= rd_nxt;
    fnd_r <= fnd_nxt;
    fidx_r <= fidx_nxt;
    cnt_out_r <= cnt_out_nxt;
    st_r <= st_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_read_value = rd_r;
  assign out_found = fnd_r;
  assign out_found_index = fidx_r;
  assign out_entry_count = cnt_out_r;
  assign out_status = st_r;

endmodule
